// ===== src/ets_pkg.sv =====
package ets_pkg;

    localparam int unsigned MAX_SOURCE_BYTES = 65536;
    localparam int unsigned POS_W = $clog2(MAX_SOURCE_BYTES + 1);
    localparam int unsigned SAT_W = (POS_W > 17) ? POS_W : 17;

    // result queue
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    typedef logic [POS_W-1:0] pos_t;

    typedef enum logic [3:0] {
        KIND_NUMBER  = 4'd0,
        KIND_IDENT   = 4'd1,
        KIND_PLUS    = 4'd2,
        KIND_MINUS   = 4'd3,
        KIND_STAR    = 4'd4,
        KIND_SLASH   = 4'd5,
        KIND_CARET   = 4'd6,
        KIND_LPAREN  = 4'd7,
        KIND_RPAREN  = 4'd8,
        KIND_COMMA   = 4'd9,
        KIND_EQUAL   = 4'd10,
        KIND_BANG    = 4'd11,
        KIND_NEWLINE = 4'd12,
        KIND_EOF     = 4'd13
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE         = 3'd0,
        ERR_UNKNOWN      = 3'd1,
        ERR_SECOND_DOT   = 3'd2,
        ERR_TRAILING_DOT = 3'd3,
        ERR_TOO_LONG     = 3'd4
    } err_t;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_NUMBER = 2'd1,
        MODE_IDENT  = 2'd2,
        MODE_SKIPWS = 2'd3
    } mode_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] start;
        logic [16:0] length;
        logic        has_dot;
        err_t        err;
        logic        last;
    } res_t;

    typedef struct packed {
        logic [1:0] cnt;
        res_t       res0;
        res_t       res1;
    } scan_out_t;

    typedef struct packed {
        logic  hit;
        kind_t kind;
    } op_t;

    function automatic logic [15:0] sat_offset(pos_t v);
        logic [SAT_W-1:0] w;
        w = SAT_W'(v);
        return (w > SAT_W'(17'h0FFFF)) ? 16'hFFFF : w[15:0];
    endfunction

    function automatic logic [16:0] sat_length(pos_t v);
        logic [SAT_W-1:0] w;
        w = SAT_W'(v);
        return (w > SAT_W'(17'h1FFFF)) ? 17'h1FFFF : w[16:0];
    endfunction

    function automatic res_t make_res(kind_t kind, logic [15:0] start, logic [16:0] length,
                                      logic has_dot, err_t err);
        res_t r;
        r.kind    = kind;
        r.start   = start;
        r.length  = length;
        r.has_dot = has_dot;
        r.err     = err;
        r.last    = 1'b0;
        return r;
    endfunction

    function automatic op_t op_lookup(logic [7:0] c);
        op_t o;
        o.hit  = 1'b1;
        o.kind = KIND_PLUS;
        unique case (c)
            CH_PLUS:   o.kind = KIND_PLUS;
            CH_MINUS:  o.kind = KIND_MINUS;
            CH_STAR:   o.kind = KIND_STAR;
            CH_SLASH:  o.kind = KIND_SLASH;
            CH_CARET:  o.kind = KIND_CARET;
            CH_LPAREN: o.kind = KIND_LPAREN;
            CH_RPAREN: o.kind = KIND_RPAREN;
            CH_COMMA:  o.kind = KIND_COMMA;
            CH_EQUAL:  o.kind = KIND_EQUAL;
            CH_BANG:   o.kind = KIND_BANG;
            default:   o.hit  = 1'b0;
        endcase
        return o;
    endfunction

endpackage

// ===== src/ets_scan.sv =====
module ets_scan (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  logic [7:0]          src_byte,
    input  logic                src_eos,
    output ets_pkg::scan_out_t  scan_out
);

    ets_pkg::mode_t mode_reg, mode_next;
    ets_pkg::pos_t  position_reg, position_next;
    ets_pkg::pos_t  token_start_reg, token_start_next;
    logic           dot_seen_reg, dot_seen_next;
    logic           last_dot_reg, last_dot_next;
    logic           halted_reg, halted_next;

    logic           is_dig, is_alp, is_sp, is_dot, is_nl, is_blank;
    ets_pkg::op_t   op;
    logic           at_limit, normal, rescan, trail_err;
    logic           close_active, idle_active, unknown_idle;
    logic           err4, dot2_err, err3, halt_set, eos_ok;
    ets_pkg::pos_t  tok_len;

    ets_pkg::res_t  slot_a, slot_b;
    logic           a_v, b_v;

    // character classes
    assign is_dig   = (src_byte >= 8'h30) && (src_byte <= 8'h39);
    assign is_alp   = ((src_byte >= 8'h61) && (src_byte <= 8'h7A)) ||
                      ((src_byte >= 8'h41) && (src_byte <= 8'h5A));
    assign is_sp    = (src_byte == ets_pkg::CH_SPACE) ||
                      ((src_byte >= ets_pkg::CH_TAB) && (src_byte <= ets_pkg::CH_CR));
    assign is_dot   = (src_byte == ets_pkg::CH_DOT);
    assign is_nl    = (src_byte == ets_pkg::CH_NL);
    assign is_blank = (src_byte == ets_pkg::CH_SPACE);
    assign op       = ets_pkg::op_lookup(src_byte);

    assign at_limit  = (position_reg >= ets_pkg::POS_W'(ets_pkg::MAX_SOURCE_BYTES));
    assign normal    = !halted_reg && !src_eos && !at_limit;
    assign trail_err = (mode_reg == ets_pkg::MODE_NUMBER) && last_dot_reg;

    always_comb begin
        unique case (mode_reg)
            ets_pkg::MODE_NUMBER: rescan = !is_dig && !is_dot;
            ets_pkg::MODE_IDENT:  rescan = !(is_alp || is_dig);
            ets_pkg::MODE_SKIPWS: rescan = !is_sp;
            default:              rescan = 1'b1;
        endcase
    end

    assign close_active = !halted_reg && (src_eos || (normal && rescan));
    assign idle_active  = normal && rescan && !trail_err;
    assign unknown_idle = !(is_dig || is_alp || is_blank || is_nl || op.hit);
    assign err4         = !halted_reg && !src_eos && at_limit;
    assign dot2_err     = normal && (mode_reg == ets_pkg::MODE_NUMBER) && is_dot && dot_seen_reg;
    assign err3         = close_active && trail_err;
    assign eos_ok       = !halted_reg && src_eos && !trail_err;
    assign halt_set     = err4 || dot2_err || err3 || (idle_active && unknown_idle);
    assign tok_len      = position_reg - token_start_reg;

    // next state
    always_comb begin
        mode_next        = mode_reg;
        position_next    = position_reg;
        token_start_next = token_start_reg;
        dot_seen_next    = dot_seen_reg;
        last_dot_next    = last_dot_reg;
        halted_next      = halted_reg;
        if (fire && !halted_reg) begin
            halted_next = halt_set;
            if (src_eos) begin
                mode_next = ets_pkg::MODE_IDLE;
            end else if (normal) begin
                if (!halt_set) begin
                    position_next = position_reg + ets_pkg::POS_W'(1);
                end
                if (rescan) begin
                    mode_next = ets_pkg::MODE_IDLE;
                    if (!trail_err) begin
                        if (is_dig) begin
                            mode_next        = ets_pkg::MODE_NUMBER;
                            token_start_next = position_reg;
                            dot_seen_next    = 1'b0;
                            last_dot_next    = 1'b0;
                        end else if (is_alp) begin
                            mode_next        = ets_pkg::MODE_IDENT;
                            token_start_next = position_reg;
                        end else if (is_nl) begin
                            mode_next = ets_pkg::MODE_SKIPWS;
                        end
                    end
                end else if (mode_reg == ets_pkg::MODE_NUMBER) begin
                    if (is_dot) begin
                        dot_seen_next = 1'b1;
                        last_dot_next = 1'b1;
                    end else begin
                        last_dot_next = 1'b0;
                    end
                end
            end
        end
    end

    // results: slot a closes a token or reports an error, slot b is the idle scan or eof
    always_comb begin
        a_v    = 1'b0;
        b_v    = 1'b0;
        slot_a = ets_pkg::make_res(ets_pkg::KIND_NUMBER, ets_pkg::sat_offset(position_reg),
                                   17'd0, 1'b0, ets_pkg::ERR_NONE);
        slot_b = slot_a;
        if (err4) begin
            a_v        = 1'b1;
            slot_a.err = ets_pkg::ERR_TOO_LONG;
        end else if (dot2_err) begin
            a_v        = 1'b1;
            slot_a.err = ets_pkg::ERR_SECOND_DOT;
        end else if (close_active) begin
            if (trail_err) begin
                a_v        = 1'b1;
                slot_a.err = ets_pkg::ERR_TRAILING_DOT;
            end else if (mode_reg == ets_pkg::MODE_NUMBER) begin
                a_v    = 1'b1;
                slot_a = ets_pkg::make_res(ets_pkg::KIND_NUMBER,
                                           ets_pkg::sat_offset(token_start_reg),
                                           ets_pkg::sat_length(tok_len), dot_seen_reg,
                                           ets_pkg::ERR_NONE);
            end else if (mode_reg == ets_pkg::MODE_IDENT) begin
                a_v    = 1'b1;
                slot_a = ets_pkg::make_res(ets_pkg::KIND_IDENT,
                                           ets_pkg::sat_offset(token_start_reg),
                                           ets_pkg::sat_length(tok_len), 1'b0,
                                           ets_pkg::ERR_NONE);
            end
        end

        if (eos_ok) begin
            b_v         = 1'b1;
            slot_b.kind = ets_pkg::KIND_EOF;
        end else if (idle_active) begin
            if (is_nl) begin
                b_v           = 1'b1;
                slot_b.kind   = ets_pkg::KIND_NEWLINE;
                slot_b.length = 17'd1;
            end else if (op.hit) begin
                b_v           = 1'b1;
                slot_b.kind   = op.kind;
                slot_b.length = 17'd1;
            end else if (unknown_idle) begin
                b_v        = 1'b1;
                slot_b.err = ets_pkg::ERR_UNKNOWN;
            end
        end

        scan_out.res0 = a_v ? slot_a : slot_b;
        scan_out.res1 = slot_b;
        scan_out.res0.last = !(a_v && b_v);
        scan_out.res1.last = 1'b1;
        if (!fire) begin
            scan_out.cnt = 2'd0;
        end else begin
            scan_out.cnt = {1'b0, a_v} + {1'b0, b_v};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= ets_pkg::MODE_IDLE;
            position_reg    <= '0;
            token_start_reg <= '0;
            dot_seen_reg    <= 1'b0;
            last_dot_reg    <= 1'b0;
            halted_reg      <= 1'b0;
        end else begin
            mode_reg        <= mode_next;
            position_reg    <= position_next;
            token_start_reg <= token_start_next;
            dot_seen_reg    <= dot_seen_next;
            last_dot_reg    <= last_dot_next;
            halted_reg      <= halted_next;
        end
    end

    a_halt_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |=> halted_reg)
        else $error("halt released without reset");

    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        position_reg <= ets_pkg::POS_W'(ets_pkg::MAX_SOURCE_BYTES))
        else $error("position ran past source limit");

    a_halted_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |-> (scan_out.cnt == 2'd0))
        else $error("result produced while halted");

    a_error_halts: assert property (@(posedge aclk) disable iff (!aresetn)
        (scan_out.cnt != 2'd0 && scan_out.res0.err != ets_pkg::ERR_NONE) |=> halted_reg)
        else $error("error result did not halt scanner");

endmodule

// ===== src/ets_out_fifo.sv =====
module ets_out_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  ets_pkg::scan_out_t  push,
    output logic                has_room,
    output ets_pkg::res_t       head,
    output logic                head_valid,
    input  logic                head_ready
);

    ets_pkg::res_t               fifo_mem [ets_pkg::QDEPTH];
    logic [ets_pkg::QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [ets_pkg::QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [ets_pkg::QCNT_W-1:0]  count_reg, count_next;
    logic                        pop;

    assign pop        = head_valid && head_ready;
    assign head_valid = (count_reg != '0);
    assign head       = fifo_mem[rd_ptr_reg];
    // room for the two beats a single item may produce
    assign has_room   = (count_reg <= ets_pkg::QCNT_W'(ets_pkg::QDEPTH - 2));

    assign wr_ptr_next = wr_ptr_reg + ets_pkg::QPTR_W'(push.cnt);
    assign rd_ptr_next = rd_ptr_reg + ets_pkg::QPTR_W'(pop);
    assign count_next  = count_reg + ets_pkg::QCNT_W'(push.cnt) - ets_pkg::QCNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (push.cnt != 2'd0) begin
            fifo_mem[wr_ptr_reg] <= push.res0;
        end
        if (push.cnt == 2'd2) begin
            fifo_mem[wr_ptr_reg + ets_pkg::QPTR_W'(1)] <= push.res1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== src/expression_token_scanner.sv =====
// Streaming lexer for arithmetic expression text. Each s_ beat carries one source byte in
// s_tdata, or an end-of-source mark in s_tuser (byte ignored); each m_ beat is one token
// (number, identifier, operator, newline, eof) with its start offset, length and dot flag,
// or an error result, after which the block stays silent until reset. m_tlast marks the
// last token caused by a source beat. A beat passes through the input register, then the
// result queue. One source beat is accepted per cycle while the four-entry result queue
// has room for two beats; since a beat can raise two tokens, the sustained rate is bounded
// by the single m_ port at one token per cycle.
module expression_token_scanner (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] source_byte
    input  logic        s_tuser,   // [0] end_of_source
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // token_kind, start_offset, token_length, has_dot, error_code
    output logic        m_tlast
);

    logic               in_valid_reg, in_valid_next;
    logic [7:0]         in_byte_reg;
    logic               in_eos_reg;
    logic               room, fire, s_fire;
    ets_pkg::scan_out_t scan_out;
    ets_pkg::res_t      head;

    assign fire          = in_valid_reg && room;
    assign s_tready      = !in_valid_reg || fire;
    assign s_fire        = s_tvalid && s_tready;
    assign in_valid_next = s_fire || (in_valid_reg && !fire);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_byte_reg <= s_tdata;
            in_eos_reg  <= s_tuser;
        end
    end

    ets_scan u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .fire     (fire),
        .src_byte (in_byte_reg),
        .src_eos  (in_eos_reg),
        .scan_out (scan_out)
    );

    ets_out_fifo u_out_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (scan_out),
        .has_room   (room),
        .head       (head),
        .head_valid (m_tvalid),
        .head_ready (m_tready)
    );

    assign m_tdata = {7'd0, head.err, head.has_dot, head.length, head.start, head.kind};
    assign m_tlast = head.last;

endmodule

// ===== verif/expression_token_scanner_checker.sv =====
`timescale 1ns / 100ps

module expression_token_scanner_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic        m_tlast,
    output int          mismatches,
    output int          pending,
    output int          tokens_seen
);

    // lexer state as the block should hold it
    ets_pkg::mode_t lex_mode;
    logic [16:0]    src_pos;
    logic [16:0]    tok_start;
    logic           frac_seen;
    logic           ends_in_dot;
    logic           stopped;

    ets_pkg::res_t beat_tokens [2];
    int            n_tok;
    ets_pkg::res_t token_q [$];

    initial begin
        mismatches  = 0;
        pending     = 0;
        tokens_seen = 0;
    end

    function automatic logic is_digit(logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_blank(logic [7:0] c);
        return c == ets_pkg::CH_SPACE || (c >= ets_pkg::CH_TAB && c <= ets_pkg::CH_CR);
    endfunction

    task automatic add_token(ets_pkg::kind_t k, logic [16:0] at, logic [16:0] len, logic dot,
                             ets_pkg::err_t code);
        ets_pkg::res_t r;
        r.kind    = k;
        r.start   = at[16] ? 16'hFFFF : at[15:0];
        r.length  = len;
        r.has_dot = dot;
        r.err     = code;
        r.last    = 1'b0;
        beat_tokens[n_tok] = r;
        n_tok++;
    endtask

    task automatic raise_error(ets_pkg::err_t code);
        stopped = 1'b1;
        add_token(ets_pkg::KIND_NUMBER, src_pos, 17'd0, 1'b0, code);
    endtask

    // emits the number or identifier that ends just before src_pos, or a trailing-dot error
    task automatic close_lexeme(output logic ok);
        ok = 1'b1;
        if (lex_mode == ets_pkg::MODE_NUMBER) begin
            if (ends_in_dot) begin
                raise_error(ets_pkg::ERR_TRAILING_DOT);
                ok = 1'b0;
            end else begin
                add_token(ets_pkg::KIND_NUMBER, tok_start, src_pos - tok_start, frac_seen,
                          ets_pkg::ERR_NONE);
            end
        end else if (lex_mode == ets_pkg::MODE_IDENT) begin
            add_token(ets_pkg::KIND_IDENT, tok_start, src_pos - tok_start, 1'b0,
                      ets_pkg::ERR_NONE);
        end
        if (ok)
            lex_mode = ets_pkg::MODE_IDLE;
    endtask

    task automatic start_lexeme(logic [7:0] c);
        ets_pkg::kind_t k;
        logic           single;
        single = 1'b1;
        k      = ets_pkg::KIND_PLUS;
        if (is_digit(c)) begin
            lex_mode    = ets_pkg::MODE_NUMBER;
            tok_start   = src_pos;
            frac_seen   = 1'b0;
            ends_in_dot = 1'b0;
            single      = 1'b0;
        end else if (is_alpha(c)) begin
            lex_mode  = ets_pkg::MODE_IDENT;
            tok_start = src_pos;
            single    = 1'b0;
        end else begin
            case (c)
                ets_pkg::CH_SPACE: single = 1'b0;
                ets_pkg::CH_NL: begin
                    lex_mode = ets_pkg::MODE_SKIPWS;
                    k        = ets_pkg::KIND_NEWLINE;
                end
                ets_pkg::CH_PLUS:   k = ets_pkg::KIND_PLUS;
                ets_pkg::CH_MINUS:  k = ets_pkg::KIND_MINUS;
                ets_pkg::CH_STAR:   k = ets_pkg::KIND_STAR;
                ets_pkg::CH_SLASH:  k = ets_pkg::KIND_SLASH;
                ets_pkg::CH_CARET:  k = ets_pkg::KIND_CARET;
                ets_pkg::CH_LPAREN: k = ets_pkg::KIND_LPAREN;
                ets_pkg::CH_RPAREN: k = ets_pkg::KIND_RPAREN;
                ets_pkg::CH_COMMA:  k = ets_pkg::KIND_COMMA;
                ets_pkg::CH_EQUAL:  k = ets_pkg::KIND_EQUAL;
                ets_pkg::CH_BANG:   k = ets_pkg::KIND_BANG;
                default: begin
                    single = 1'b0;
                    raise_error(ets_pkg::ERR_UNKNOWN);
                end
            endcase
        end
        if (single)
            add_token(k, src_pos, 17'd1, 1'b0, ets_pkg::ERR_NONE);
    endtask

    task automatic predict_beat(logic [7:0] c, logic eos);
        logic ok;
        logic rescan;
        int   i;
        n_tok = 0;
        if (!stopped) begin
            if (eos) begin
                close_lexeme(ok);
                if (ok)
                    add_token(ets_pkg::KIND_EOF, src_pos, 17'd0, 1'b0, ets_pkg::ERR_NONE);
            end else if (src_pos >= ets_pkg::MAX_SOURCE_BYTES) begin
                raise_error(ets_pkg::ERR_TOO_LONG);
            end else begin
                rescan = 1'b0;
                case (lex_mode)
                    ets_pkg::MODE_NUMBER: begin
                        if (is_digit(c)) begin
                            ends_in_dot = 1'b0;
                        end else if (c == ets_pkg::CH_DOT) begin
                            if (frac_seen)
                                raise_error(ets_pkg::ERR_SECOND_DOT);
                            frac_seen   = 1'b1;
                            ends_in_dot = 1'b1;
                        end else begin
                            rescan = 1'b1;
                        end
                    end
                    ets_pkg::MODE_IDENT: rescan = !(is_alpha(c) || is_digit(c));
                    ets_pkg::MODE_SKIPWS: begin
                        if (!is_blank(c)) begin
                            lex_mode = ets_pkg::MODE_IDLE;
                            rescan   = 1'b1;
                        end
                    end
                    default: rescan = 1'b1;
                endcase
                if (rescan) begin
                    close_lexeme(ok);
                    if (ok)
                        start_lexeme(c);
                end
                if (!stopped)
                    src_pos++;
            end
        end
        if (n_tok > 0)
            beat_tokens[n_tok-1].last = 1'b1;
        for (i = 0; i < n_tok; i++)
            token_q.push_back(beat_tokens[i]);
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_token();
        ets_pkg::res_t want;
        if (token_q.size() == 0) begin
            $error("token beat with none expected: m_tdata=%h m_tlast=%b", m_tdata, m_tlast);
            mismatches++;
        end else begin
            want = token_q.pop_front();
            tokens_seen++;
            check_field("token_kind", want.kind, m_tdata[3:0]);
            check_field("start_offset", want.start, m_tdata[19:4]);
            check_field("token_length", want.length, m_tdata[36:20]);
            check_field("has_dot", want.has_dot, m_tdata[37]);
            check_field("error_code", want.err, m_tdata[40:38]);
            check_field("last_result", want.last, m_tlast);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            lex_mode    = ets_pkg::MODE_IDLE;
            src_pos     = '0;
            tok_start   = '0;
            frac_seen   = 1'b0;
            ends_in_dot = 1'b0;
            stopped     = 1'b0;
            token_q.delete();
        end else begin
            if (s_tvalid && s_tready)
                predict_beat(s_tdata, s_tuser);
            if (m_tvalid && m_tready)
                check_token();
        end
        pending = token_q.size();
    end

endmodule

// ===== verif/expression_token_scanner_tb.sv =====
`timescale 1ns / 100ps

module expression_token_scanner_tb;

    localparam int RANDOM_BEATS = 600;
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam logic [7:0] CH_VT = 8'h0B;
    localparam logic [7:0] CH_FF = 8'h0C;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tlast;

    int chk_errors;
    int chk_pending;
    int chk_tokens;

    int          beats_sent  = 0;
    int          marks_sent  = 0;
    logic [16:0] byte_pos    = '0;
    int          burst_left  = 0;
    bit          after_number = 1'b0;
    int          cycle_count = 0;
    int          rx_mode     = 0;
    int          rx_left     = 0;

    logic [7:0] op_chars [10] = '{ets_pkg::CH_PLUS, ets_pkg::CH_MINUS, ets_pkg::CH_STAR,
                                  ets_pkg::CH_SLASH, ets_pkg::CH_CARET, ets_pkg::CH_LPAREN,
                                  ets_pkg::CH_RPAREN, ets_pkg::CH_COMMA, ets_pkg::CH_EQUAL,
                                  ets_pkg::CH_BANG};
    logic [7:0] ws_chars [6]  = '{ets_pkg::CH_SPACE, ets_pkg::CH_TAB, ets_pkg::CH_NL, CH_VT,
                                  CH_FF, ets_pkg::CH_CR};

    expression_token_scanner uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    expression_token_scanner_checker scan_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .mismatches  (chk_errors),
        .pending     (chk_pending),
        .tokens_seen (chk_tokens)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // result side: alternates between always-ready stretches and stall patterns
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(20, 200);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            0, 1: m_tready <= 1'b1;
            2: m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    function automatic logic [7:0] rand_digit();
        return 8'h30 + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_letter();
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'($urandom_range(0, 25));
    endfunction

    // a byte that is no valid token start in idle mode
    function automatic logic [7:0] odd_byte();
        logic [7:0] b;
        int         i;
        bit         known;
        case ($urandom_range(0, 3))
            0: b = ets_pkg::CH_DOT;
            1: b = ets_pkg::CH_TAB;
            2: b = ets_pkg::CH_CR;
            default: begin
                do begin
                    b = 8'($urandom_range(0, 255));
                    known = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h7A) ||
                            (b >= 8'h41 && b <= 8'h5A) || b == ets_pkg::CH_SPACE ||
                            b == ets_pkg::CH_NL;
                    for (i = 0; i < 10; i++)
                        if (b == op_chars[i])
                            known = 1'b1;
                end while (known);
            end
        endcase
        return b;
    endfunction

    // entered and left at a falling edge
    task automatic send_beat(input logic [7:0] b, input logic eos);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) begin
                gap = $urandom_range(1, 8);
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= eos;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        beats_sent++;
        if (eos)
            marks_sent++;
        else
            byte_pos++;
    endtask

    task automatic drain_results();
        if (chk_pending != 0) begin
            s_tvalid <= 1'b0;
            while (chk_pending != 0) @(negedge aclk);
        end
    endtask

    // one well-formed lexeme: numbers never run into each other, dots always inside
    task automatic send_lexeme();
        int pick;
        int n;
        int i;
        pick = $urandom_range(0, 19);
        if (pick < 6) begin
            if (after_number)
                send_beat(ets_pkg::CH_SPACE, 1'b0);
            n = ($urandom_range(0, 15) == 0) ? $urandom_range(6, 40) : $urandom_range(1, 4);
            for (i = 0; i < n; i++)
                send_beat(rand_digit(), 1'b0);
            if ($urandom_range(0, 2) == 0) begin
                send_beat(ets_pkg::CH_DOT, 1'b0);
                n = $urandom_range(1, 3);
                for (i = 0; i < n; i++)
                    send_beat(rand_digit(), 1'b0);
            end
            after_number = 1'b1;
        end else begin
            after_number = 1'b0;
            if (pick < 10) begin
                send_beat(rand_letter(), 1'b0);
                n = $urandom_range(0, 7);
                for (i = 0; i < n; i++)
                    send_beat($urandom_range(0, 2) == 0 ? rand_digit() : rand_letter(), 1'b0);
            end else if (pick < 16) begin
                send_beat(op_chars[$urandom_range(0, 9)], 1'b0);
            end else if (pick < 18) begin
                n = $urandom_range(1, 2);
                for (i = 0; i < n; i++)
                    send_beat(ets_pkg::CH_SPACE, 1'b0);
            end else if (pick < 19) begin
                send_beat(ets_pkg::CH_NL, 1'b0);
                n = $urandom_range(0, 3);
                for (i = 0; i < n; i++)
                    send_beat(ws_chars[$urandom_range(0, 5)], 1'b0);
            end else begin
                send_beat(8'($urandom_range(0, 255)), 1'b1);
            end
        end
    endtask

    initial begin
        string         demo;
        int            i;
        int            last_drain;
        int            random_end;
        ets_pkg::err_t final_err;

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        // every operator, digit and letter extremes, a fraction, newline with skipped blanks
        demo = "0.9+Za9-z*(A)/1^2,x=!\n\t ";
        for (i = 0; i < demo.len(); i++)
            send_beat(demo[i], 1'b0);
        send_beat(8'hFF, 1'b1);

        last_drain = beats_sent;
        random_end = beats_sent + RANDOM_BEATS;
        while (beats_sent < random_end) begin
            send_lexeme();
            if (beats_sent - last_drain >= 150) begin
                drain_results();
                last_drain = beats_sent;
            end
        end

        // the first error halts the block for good, so one kind is picked per run
        final_err = ets_pkg::err_t'($urandom_range(1, 3));
        case (final_err)
            ets_pkg::ERR_UNKNOWN: begin
                send_beat(ets_pkg::CH_PLUS, 1'b0);
                send_beat(odd_byte(), 1'b0);
            end
            ets_pkg::ERR_SECOND_DOT: begin
                send_beat(ets_pkg::CH_PLUS, 1'b0);
                send_beat(8'h31, 1'b0);
                send_beat(ets_pkg::CH_DOT, 1'b0);
                send_beat(8'h32, 1'b0);
                send_beat(ets_pkg::CH_DOT, 1'b0);
            end
            default: begin
                send_beat(ets_pkg::CH_PLUS, 1'b0);
                send_beat(8'h37, 1'b0);
                send_beat(ets_pkg::CH_DOT, 1'b0);
                send_beat(8'($urandom_range(0, 255)), 1'b1);
            end
        endcase

        // halted: these beats must raise nothing
        for (i = 0; i < 12; i++)
            send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

        s_tvalid <= 1'b0;
        while (chk_pending != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);

        $display("scanned %0d source beats (%0d end marks) up to offset %0d, checked %0d tokens",
                 beats_sent, marks_sent, byte_pos, chk_tokens);
        $display("run closed with a %s error and a halted stretch", final_err.name());
        if (chk_errors == 0 && chk_pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
src/ets_pkg.sv
src/ets_scan.sv
src/ets_out_fifo.sv
src/expression_token_scanner.sv
verif/expression_token_scanner_checker.sv
verif/expression_token_scanner_tb.sv
